// File: hw/rtl/srg_pkg.sv
package srg_pkg;

  // Result kinds as they leave the block.
  typedef logic [2:0] kind_t;

  localparam kind_t KIND_SINGLE   = 3'd0;
  localparam kind_t KIND_RANGE    = 3'd1;
  localparam kind_t KIND_LACE_P   = 3'd2;
  localparam kind_t KIND_LACE_M   = 3'd3;
  localparam kind_t KIND_LIST_END = 3'd4;

  // Open run. The codes match the low bits of the matching result kind.
  typedef logic [1:0] run_mode_t;

  localparam run_mode_t RUN_NONE   = 2'd0;
  localparam run_mode_t RUN_RANGE  = 2'd1;
  localparam run_mode_t RUN_LACE_P = 2'd2;
  localparam run_mode_t RUN_LACE_M = 2'd3;

  // Largest number of results that one input transaction can cause.
  localparam int MAX_RESULTS = 3;

  // Results of one input transaction, oldest in entry 0.
  typedef struct packed {
    logic [1:0]                   cnt;
    kind_t [MAX_RESULTS-1:0]      kinds;
  } bundle_t;

endpackage

// File: hw/rtl/srg_step.sv
module srg_step #(
  parameter int CODE_BITS = 21
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 fire,
  input  logic                 use_cases,
  input  logic [CODE_BITS-1:0] code,
  input  logic [CODE_BITS-1:0] case_value,
  input  logic                 list_end,
  output srg_pkg::bundle_t     bundle
);

  import srg_pkg::*;

  localparam logic [CODE_BITS-1:0] ONE = CODE_BITS'(1);
  localparam logic [CODE_BITS-1:0] TWO = CODE_BITS'(2);

  logic [CODE_BITS-1:0] held_code_r;
  logic [CODE_BITS-1:0] held_case_r;
  logic                 have_held_r;
  run_mode_t            run_mode_r;
  logic                 after_run_end_r;

  run_mode_t            run_mode_nxt;
  logic                 after_run_end_nxt;
  logic                 have_held_nxt;

  logic                 pair_rng;
  logic                 pair_lp;
  logic                 pair_lm;
  logic                 step_two;

  // Pair tests between the held element and the new one; sums wrap.
  assign step_two = (code == held_code_r + TWO);
  assign pair_rng = (code == held_code_r + ONE) &&
                    (!use_cases || (case_value == held_case_r + ONE));
  assign pair_lp  = step_two && (!use_cases ||
                    ((held_case_r == held_code_r + ONE) && (case_value == code + ONE)));
  assign pair_lm  = step_two && (!use_cases ||
                    ((held_case_r == held_code_r - ONE) && (case_value == code - ONE)));

  always_comb begin
    logic      cont;
    logic      examine;
    run_mode_t mode;
    logic      after;
    logic      have;
    logic [1:0] n;
    kind_t [MAX_RESULTS-1:0] kinds;

    mode    = run_mode_r;
    after   = after_run_end_r;
    have    = 1'b1;
    n       = 2'd0;
    kinds   = '0;
    examine = 1'b1;

    case (run_mode_r)
      RUN_RANGE:  cont = pair_rng;
      RUN_LACE_P: cont = pair_lp;
      RUN_LACE_M: cont = pair_lm;
      default:    cont = 1'b0;
    endcase

    if (have_held_r) begin
      if (mode != RUN_NONE) begin
        if (cont) begin
          examine = 1'b0;
        end else begin
          kinds[n] = {1'b0, mode};
          n        = n + 2'd1;
          mode     = RUN_NONE;
          after    = 1'b1;
        end
      end
      if (examine) begin
        if (pair_rng) begin
          mode = RUN_RANGE;
        end else if (pair_lp) begin
          mode = RUN_LACE_P;
        end else if (pair_lm) begin
          mode = RUN_LACE_M;
        end
        if (mode == RUN_NONE) begin
          // An element that just closed a run and begins nothing is dropped.
          if (!after) begin
            kinds[n] = KIND_SINGLE;
            n        = n + 2'd1;
          end
        end
        after = 1'b0;
      end
    end

    if (list_end) begin
      if (mode != RUN_NONE) begin
        kinds[n] = {1'b0, mode};
        n        = n + 2'd1;
      end else if (!after) begin
        kinds[n] = KIND_SINGLE;
        n        = n + 2'd1;
      end
      kinds[n] = KIND_LIST_END;
      n        = n + 2'd1;
      mode     = RUN_NONE;
      after    = 1'b0;
      have     = 1'b0;
    end

    run_mode_nxt      = mode;
    after_run_end_nxt = after;
    have_held_nxt     = have;
    bundle.cnt        = n;
    bundle.kinds      = kinds;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      have_held_r     <= 1'b0;
      run_mode_r      <= RUN_NONE;
      after_run_end_r <= 1'b0;
      held_code_r     <= '0;
      held_case_r     <= '0;
    end else if (fire) begin
      have_held_r     <= have_held_nxt;
      run_mode_r      <= run_mode_nxt;
      after_run_end_r <= after_run_end_nxt;
      held_code_r     <= list_end ? '0 : code;
      held_case_r     <= list_end ? '0 : case_value;
    end
  end

endmodule

// File: hw/rtl/srg_out_queue.sv
module srg_out_queue (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             load,
  input  srg_pkg::bundle_t bundle,
  input  logic             out_stall,
  output logic             out_valid,
  output srg_pkg::kind_t   out_kind,
  output logic             free
);

  import srg_pkg::*;

  logic [1:0]              cnt_r;
  kind_t [MAX_RESULTS-1:0] kinds_r;
  logic                    pop;

  assign out_valid = (cnt_r != 2'd0);
  assign out_kind  = kinds_r[0];
  assign pop       = out_valid && !out_stall;
  // The slot can take a new bundle once its last result leaves this cycle.
  assign free      = (cnt_r == 2'd0) || ((cnt_r == 2'd1) && !out_stall);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= 2'd0;
    end else if (load) begin
      cnt_r <= bundle.cnt;
    end else if (pop) begin
      cnt_r <= cnt_r - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      kinds_r <= bundle.kinds;
    end else if (pop) begin
      kinds_r <= {KIND_SINGLE, kinds_r[MAX_RESULTS-1:1]};
    end
  end

endmodule

// File: hw/rtl/sorted_code_run_grouper.sv
// Channel | Direction | Ports                                    | Handshake
// --------+-----------+------------------------------------------+---------------------
// in      | input     | in_code, in_case_value, in_list_end      | in_valid / in_stall
// out     | output    | out_kind                                 | out_valid / out_stall
// cfg     | input     | cfg_wdata (use_cases)                    | cfg_we, no wait
//
// An input transaction enters an input register, and once the queue is free the run
// logic turns it into a bundle of zero to three results held in the result queue.
// One result leaves per cycle unless out_stall is high; the queue takes a new bundle
// as its last result leaves, so the input register refills while it drains.
// Reset (rst_n low at a clock edge) clears the list state, the queue and use_cases.
// A stalled output holds the queue, then the input register, then in_stall rises.
module sorted_code_run_grouper #(
  parameter int CODE_BITS = 21
) (
  input  logic                 clk,
  input  logic                 rst_n,

  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic [CODE_BITS-1:0] in_code,
  input  logic [CODE_BITS-1:0] in_case_value,
  input  logic                 in_list_end,

  output logic                 out_valid,
  input  logic                 out_stall,
  output srg_pkg::kind_t       out_kind,

  input  logic                 cfg_we,
  input  logic                 cfg_wdata
);

  import srg_pkg::*;

  // The use_cases register adds the mapping checks to the range and lace tests.
  logic                 use_cases_r;

  // Input register in front of the run logic.
  logic                 in_valid_r;
  logic [CODE_BITS-1:0] code_r;
  logic [CODE_BITS-1:0] case_value_r;
  logic                 list_end_r;

  logic                 q_free;
  logic                 advance;
  logic                 in_take;
  bundle_t              bundle;

  // The held item moves into the run logic when the queue can take its results.
  assign advance  = in_valid_r && q_free;
  // The input register accepts a transaction when empty or emptying this cycle.
  assign in_stall = in_valid_r && !q_free;
  assign in_take  = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      use_cases_r <= 1'b0;
    end else if (cfg_we) begin
      use_cases_r <= cfg_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_take) begin
      in_valid_r <= 1'b1;
    end else if (advance) begin
      in_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      code_r       <= in_code;
      case_value_r <= in_case_value;
      list_end_r   <= in_list_end;
    end
  end

  // Run tracking: compares each code with the held predecessor and reports
  // the runs that close and the lone elements, plus the list end marker.
  srg_step #(
    .CODE_BITS (CODE_BITS)
  ) u_step (
    .clk        (clk),
    .rst_n      (rst_n),
    .fire       (advance),
    .use_cases  (use_cases_r),
    .code       (code_r),
    .case_value (case_value_r),
    .list_end   (list_end_r),
    .bundle     (bundle)
  );

  // Result queue: hands the bundle out one transaction at a time.
  srg_out_queue u_out_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .load      (advance),
    .bundle    (bundle),
    .out_stall (out_stall),
    .out_valid (out_valid),
    .out_kind  (out_kind),
    .free      (q_free)
  );

endmodule

// File: tb/sv/testbench.sv
`timescale 1ns / 1ps

// Self-checking bench for sorted_code_run_grouper.
//
// A small scoreboard class carries its own copy of the grouping state and of
// the use_cases register. The monitor feeds it every accepted input
// transaction, and it turns each one into the run kinds that the block must
// report. Every accepted output transaction is then checked against the
// oldest kind still due.
//
// The stimulus starts with a short hand-written sequence that covers the
// lowest and highest codes, every result kind, one-element lists, repeated and
// descending codes, and a register change in the middle of an open list.
// After that come random phases made mostly of well-formed lists. These are
// built from ranges, laces in both directions, singles and repeats, with a
// little noise and some broken mappings. The phases alternate the register,
// and turn random idling on both channels on and off. In one phase the
// receiver holds off for a long stretch while the sender keeps offering
// items, so that the block fills up and stalls its input.
module testbench;
  import srg_pkg::*;

  localparam int CODE_W = 21;
  localparam int MAX_CODE = 1114111;
  // Cycles the block may still spend on a transaction that yields no result.
  localparam int SETTLE_CYCLES = 8;
  localparam int DRAIN_CYCLES = 20;
  localparam int DRAIN_LIMIT = 5000;
  localparam int HOLD_CYCLES = 80;
  localparam int PHASE_ITEMS = 18;
  // Room for the kinds still due; the block holds far fewer than this.
  localparam int DUE_DEPTH = 64;
  // Room for the longest list that send_list can build: five segments of six elements.
  localparam int LIST_MAX = 32;

  typedef logic [CODE_W-1:0] code_t;

  typedef struct packed {
    code_t code;
    code_t cval;
    logic  last;
  } code_item_t;

  // Steps between neighbors of a lace, and the two lace mapping offsets.
  localparam code_t LACE_STRIDE = code_t'(2);
  localparam code_t STEP_UP = code_t'(1);
  localparam code_t STEP_DOWN = '1;

  // Predicts the run kinds of each list and checks the results against them.
  class run_scoreboard;
    logic      cases_on;
    code_t     held_code;
    code_t     held_case;
    logic      have_held;
    logic      after_run;
    run_mode_t open_run;
    kind_t     due_kinds[DUE_DEPTH];
    int        due_head;
    int        due_count;
    int        errors;
    int        n_inputs;
    int        n_lists;
    int        n_results;
    int        kind_count[5];

    function new();
      cases_on = 1'b0;
      due_head = 0;
      due_count = 0;
      errors = 0;
      n_inputs = 0;
      n_lists = 0;
      n_results = 0;
      foreach (kind_count[i]) kind_count[i] = 0;
      clear_list();
    endfunction

    function void clear_list();
      held_code = '0;
      held_case = '0;
      have_held = 1'b0;
      after_run = 1'b0;
      open_run = RUN_NONE;
    endfunction

    function void set_cases(logic val);
      cases_on = val;
    endfunction

    // Appends a kind to the ring of kinds still due.
    function void due_add(kind_t k);
      if (due_count == DUE_DEPTH) begin
        errors++;
        $display("%0t: scoreboard full, expected kind %0d dropped", $time, k);
      end else begin
        due_kinds[(due_head + due_count) % DUE_DEPTH] = k;
        due_count++;
      end
    endfunction

    // Takes the oldest kind still due.
    function kind_t due_take();
      kind_t k;
      k = due_kinds[due_head];
      due_head = (due_head + 1) % DUE_DEPTH;
      due_count--;
      return k;
    endfunction

    function logic range_step(code_t h, code_t hc, code_t c, code_t v);
      code_t h_next;
      code_t hc_next;
      h_next = h + STEP_UP;
      hc_next = hc + STEP_UP;
      if (c != h_next) return 1'b0;
      return !cases_on || (v == hc_next);
    endfunction

    function logic lace_step(code_t h, code_t hc, code_t c, code_t v, code_t dir);
      code_t h_two;
      code_t h_map;
      code_t c_map;
      h_two = h + LACE_STRIDE;
      h_map = h + dir;
      c_map = c + dir;
      if (c != h_two) return 1'b0;
      if (!cases_on) return 1'b1;
      return (hc == h_map) && (v == c_map);
    endfunction

    function logic run_goes_on(run_mode_t m, code_t c, code_t v);
      case (m)
        RUN_RANGE:  return range_step(held_code, held_case, c, v);
        RUN_LACE_P: return lace_step(held_code, held_case, c, v, STEP_UP);
        default:    return lace_step(held_code, held_case, c, v, STEP_DOWN);
      endcase
    endfunction

    // One accepted input transaction: queue the kinds it closes.
    function void note_input(code_t c, code_t v, logic last);
      logic      examine;
      run_mode_t fresh;
      n_inputs++;
      if (have_held) begin
        examine = 1'b1;
        if (open_run != RUN_NONE) begin
          if (run_goes_on(open_run, c, v)) begin
            examine = 1'b0;
          end else begin
            due_add(kind_t'(open_run));
            open_run = RUN_NONE;
            after_run = 1'b1;
          end
        end
        if (examine) begin
          fresh = RUN_NONE;
          if (range_step(held_code, held_case, c, v)) fresh = RUN_RANGE;
          else if (lace_step(held_code, held_case, c, v, STEP_UP)) fresh = RUN_LACE_P;
          else if (lace_step(held_code, held_case, c, v, STEP_DOWN)) fresh = RUN_LACE_M;
          if (fresh != RUN_NONE) begin
            open_run = fresh;
          end else if (!after_run) begin
            due_add(KIND_SINGLE);
          end
          after_run = 1'b0;
        end
      end
      held_code = c;
      held_case = v;
      have_held = 1'b1;
      if (last) begin
        if (open_run != RUN_NONE) due_add(kind_t'(open_run));
        else if (!after_run) due_add(KIND_SINGLE);
        due_add(KIND_LIST_END);
        n_lists++;
        clear_list();
      end
    endfunction

    // One accepted output transaction.
    function void check_result(kind_t got);
      kind_t want;
      n_results++;
      if (got <= KIND_LIST_END) kind_count[got]++;
      if (due_count == 0) begin
        errors++;
        $display("%0t: unexpected result, expected none, actual kind %0d", $time, got);
      end else begin
        want = due_take();
        if (got !== want) begin
          errors++;
          $display("%0t: result kind mismatch, expected %0d, actual %0d",
                   $time, want, got);
        end
      end
    endfunction
  endclass

  logic  clk;
  logic  rst_n = 1'b0;
  logic  in_valid = 1'b0;
  logic  in_stall;
  code_t in_code = '0;
  code_t in_case_value = '0;
  logic  in_list_end = 1'b0;
  logic  out_valid;
  logic  out_stall = 1'b0;
  kind_t out_kind;
  logic  cfg_we = 1'b0;
  logic  cfg_wdata = 1'b0;

  // Idling controls, set per phase by the stimulus process.
  logic  gap_en = 1'b0;
  logic  stall_en = 1'b0;
  logic  hold_req = 1'b0;
  int    stall_left = 0;

  run_scoreboard sb;

  sorted_code_run_grouper #(
    .CODE_BITS(CODE_W)
  ) i_dut (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_code      (in_code),
    .in_case_value(in_case_value),
    .in_list_end  (in_list_end),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .out_kind     (out_kind),
    .cfg_we       (cfg_we),
    .cfg_wdata    (cfg_wdata)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // The receiver counts its own stall cycles. A hold request from the stimulus
  // turns into one long hold-off, and otherwise random stalls are mostly short.
  always @(posedge clk) begin
    if (hold_req && stall_left == 0) begin
      stall_left = HOLD_CYCLES;
      hold_req = 1'b0;
    end else if (stall_left == 0 && stall_en && $urandom_range(0, 3) == 0) begin
      stall_left = ($urandom_range(0, 7) == 0) ? $urandom_range(10, 40)
                                               : $urandom_range(1, 3);
    end
    if (stall_left > 0) begin
      out_stall <= 1'b1;
      stall_left--;
    end else begin
      out_stall <= 1'b0;
    end
  end

  // The monitor samples at the clock edge. It sees the values that were
  // present at that edge, before any of this step's nonblocking updates land.
  always @(posedge clk) begin
    if (rst_n) begin
      if (cfg_we) sb.set_cases(cfg_wdata);
      if (in_valid && !in_stall) sb.note_input(in_code, in_case_value, in_list_end);
      if (out_valid && !out_stall) sb.check_result(out_kind);
    end
  end

  // Offers one input transaction, after an optional random gap, and returns
  // at the edge where it is accepted. A gap always waits on the clock before
  // in_valid rises, so in_valid is never lowered and raised in the same step.
  task automatic send_item(input code_t c, input code_t v, input logic last);
    int gap;
    if (gap_en && $urandom_range(0, 2) == 0) begin
      gap = ($urandom_range(0, 7) == 0) ? $urandom_range(10, 30) : $urandom_range(1, 3);
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_code <= c;
    in_case_value <= v;
    in_list_end <= last;
    do @(posedge clk); while (in_stall);
  endtask

  // Waits until the block is idle, then writes use_cases. The first edge lets
  // the monitor note a transaction accepted in this very step.
  task automatic write_cases(input logic val);
    in_valid <= 1'b0;
    do @(posedge clk); while (sb.due_count != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
    cfg_we <= 1'b1;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  // Builds one mostly ascending list out of random segments, then sends it with the
  // end flag on its final element.
  task automatic send_list(output int n_sent);
    code_item_t items[LIST_MAX];
    int         n_items;
    int         n_segs;
    int         len;
    int         sel;
    int         cur;
    int         c;
    int         v;
    int         base;
    n_items = 0;
    n_segs = $urandom_range(1, 5);
    cur = ($urandom_range(0, 5) == 0) ? $urandom_range(MAX_CODE - 200, MAX_CODE - 160)
                                      : $urandom_range(1, 2000);
    c = cur;
    for (int s = 0; s < n_segs; s++) begin
      if (cur > MAX_CODE - 40) cur = $urandom_range(1, 1000);
      sel = $urandom_range(0, 9);
      len = $urandom_range(2, 6);
      base = $urandom_range(0, MAX_CODE - 10);
      for (int i = 0; i < len; i++) begin
        case (sel)
          0, 1, 2: begin
            c = cur + i;
            v = base + i;
          end
          3, 4: begin
            c = cur + 2 * i;
            v = c + 1;
          end
          5, 6: begin
            c = cur + 2 * i;
            v = c - 1;
          end
          7: begin
            c = cur;
            v = $urandom_range(0, MAX_CODE);
          end
          8: begin
            c = $urandom_range(0, MAX_CODE);
            v = $urandom_range(0, MAX_CODE);
          end
          default: begin
            // Repeated code: the same element more than once.
            c = cur;
            v = base;
          end
        endcase
        if ($urandom_range(0, 9) == 0) v = $urandom_range(0, MAX_CODE);
        items[n_items] = '{code: code_t'(c), cval: code_t'(v), last: 1'b0};
        n_items++;
        if (sel == 7 || (sel == 8 && i == 1)) break;
      end
      cur = c + $urandom_range(1, 12);
    end
    items[n_items - 1].last = 1'b1;
    for (int i = 0; i < n_items; i++) send_item(items[i].code, items[i].cval, items[i].last);
    n_sent = n_items;
  endtask

  initial begin
    int sent;
    int n;
    int waited;
    sb = new();
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed part, mappings ignored.
    write_cases(1'b0);
    send_item(code_t'(0), code_t'(0), 1'b1);                  // one-element list, lowest
    send_item(code_t'(MAX_CODE), code_t'(MAX_CODE), 1'b1);    // one-element list, highest
    send_item(code_t'(10), code_t'(0), 1'b0);                 // range 10..12
    send_item(code_t'(11), code_t'(0), 1'b0);
    send_item(code_t'(12), code_t'(0), 1'b0);
    send_item(code_t'(14), code_t'(0), 1'b0);                 // step of two: lace plus one
    send_item(code_t'(16), code_t'(0), 1'b0);
    send_item(code_t'(16), code_t'(0), 1'b0);                 // repeated code
    send_item(code_t'(3), code_t'(0), 1'b0);                  // descending code
    send_item(code_t'(20), code_t'(99), 1'b0);                // range opens, list stays open
    send_item(code_t'(21), code_t'(5), 1'b0);

    // Mappings now count, in the middle of the open list.
    write_cases(1'b1);
    send_item(code_t'(22), code_t'(6), 1'b0);                 // range goes on
    send_item(code_t'(23), code_t'(50), 1'b0);                // mapping breaks it
    send_item(code_t'(100), code_t'(101), 1'b0);              // lace plus one
    send_item(code_t'(102), code_t'(103), 1'b0);
    send_item(code_t'(104), code_t'(105), 1'b0);
    send_item(code_t'(200), code_t'(199), 1'b0);              // lace minus one
    send_item(code_t'(202), code_t'(201), 1'b0);
    send_item(code_t'(204), code_t'(203), 1'b0);
    send_item(code_t'(300), code_t'(500), 1'b0);              // range with a broken tail
    send_item(code_t'(301), code_t'(501), 1'b0);
    send_item(code_t'(302), code_t'(777), 1'b0);
    send_item(code_t'(1048576), code_t'(1048577), 1'b1);

    // Random phases. Phase 2 is the hold-off phase, and phase 5 runs
    // without any idling.
    for (int ph = 0; ph < 6; ph++) begin
      write_cases(ph % 2 == 1);
      gap_en = (ph != 2 && ph != 5);
      stall_en = (ph != 3 && ph != 5);
      if (ph == 2) hold_req = 1'b1;
      sent = 0;
      while (sent < PHASE_ITEMS) begin
        send_list(n);
        sent += n;
      end
    end

    // Drain, then give a stray result time to show up.
    in_valid <= 1'b0;
    waited = 0;
    do begin
      @(posedge clk);
      waited++;
    end while (sb.due_count != 0 && waited < DRAIN_LIMIT);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (sb.due_count != 0) begin
      sb.errors++;
      $display("%0t: %0d expected results never arrived", $time, sb.due_count);
    end

    $display("Run: %0d input transactions in %0d lists, %0d results checked.",
             sb.n_inputs, sb.n_lists, sb.n_results);
    $display("Kinds seen: single %0d, range %0d, lace+1 %0d, lace-1 %0d, list end %0d.",
             sb.kind_count[0], sb.kind_count[1], sb.kind_count[2], sb.kind_count[3],
             sb.kind_count[4]);
    if (sb.errors == 0) begin
      $display("testbench OK");
    end else begin
      $display("testbench NOT OK");
    end
    $finish;
  end

  // Generous bound on the whole run.
  initial begin
    #2000000;
    $display("testbench NOT OK");
    $finish;
  end

endmodule
